// ===== rtl/core/dq_pkg.sv =====
// package for the double-ended queue: sizes, codes, request and result types
// and the ring position helper; no dependencies
package dq_pkg;

    localparam int DQ_CAPACITY = 256;
    localparam int ADDR_W      = $clog2(DQ_CAPACITY);
    localparam int CNT_W       = $clog2(DQ_CAPACITY + 1);
    localparam int WORD_W      = 32;

    localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(DQ_CAPACITY);
    localparam logic [ADDR_W:0]   CAP_EXT = (ADDR_W + 1)'(DQ_CAPACITY);
    localparam logic [ADDR_W-1:0] CAP_M1  = ADDR_W'(DQ_CAPACITY - 1);

    typedef enum logic [2:0] {
        FN_NONE       = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_PUSH_FRONT = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_POP_FRONT  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_ENDS,
        S_RD_INDEX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [WORD_W-1:0] value;
        logic [7:0]               index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic [8:0]               count;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic signed [WORD_W-1:0] indexed_value;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_mem_req;

    typedef struct packed {
        logic [WORD_W-1:0] rd_a;
        logic [WORD_W-1:0] rd_b;
    } t_mem_rsp;

    // (head + off) mod capacity, both operands below capacity
    function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] head,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= CAP_EXT) begin
            sum = sum - CAP_EXT;
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/dq_ram.sv =====
// ring store: one write port, two read ports, read data registered
// depends on dq_pkg
module dq_ram (
    input  logic            i_clk,
    input  dq_pkg::t_mem_req i_req,
    output dq_pkg::t_mem_rsp o_rsp
);
    import dq_pkg::*;

    logic [WORD_W-1:0] r_mem [DQ_CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rsp.rd_a <= r_mem[i_req.raddr_a];
        o_rsp.rd_b <= r_mem[i_req.raddr_b];
    end

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// queue sequencer: pointer update and store write on accept, then reads of
// the ends and the indexed word, and the result register; depends on dq_pkg
module dq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dq_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dq_pkg::t_out_item o_out_item,
    output dq_pkg::t_mem_req  o_mem_req,
    input  dq_pkg::t_mem_rsp  i_mem_rsp
);
    import dq_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    t_status           r_status, n_status;
    logic [7:0]        r_index;
    logic [WORD_W-1:0] r_front, r_back;
    logic              r_out_valid, n_out_valid;
    logic              load_out;
    logic              accept;
    logic              idx_ok;

    assign accept = i_in_valid && o_in_ready;
    assign idx_ok = {1'b0, r_index} < r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_index  <= i_in_item.index;
            r_status <= n_status;
        end
        // read data of the ends arrives during the index read
        if (r_state == S_RD_INDEX) begin
            r_front <= (r_count != '0) ? i_mem_rsp.rd_a : '0;
            r_back  <= (r_count != '0) ? i_mem_rsp.rd_b : '0;
        end
        if (load_out) begin
            o_out_item.status        <= (r_status != ST_OK) ? r_status :
                                        (idx_ok ? ST_OK : ST_BAD_INDEX);
            o_out_item.count         <= r_count;
            o_out_item.front_value   <= r_front;
            o_out_item.back_value    <= r_back;
            o_out_item.indexed_value <= idx_ok ? i_mem_rsp.rd_a : '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_status    = ST_OK;
        o_in_ready  = 1'b0;
        load_out    = 1'b0;
        o_mem_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_RD_ENDS;
                    unique case (i_in_item.func)
                        FN_PUSH_BACK: begin
                            if (r_count >= CAP_CNT) begin
                                n_status = ST_PUSH_FULL;
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = ring_pos(r_head, r_count[ADDR_W-1:0]);
                                o_mem_req.wdata = i_in_item.value;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        FN_PUSH_FRONT: begin
                            if (r_count >= CAP_CNT) begin
                                n_status = ST_PUSH_FULL;
                            end else begin
                                n_head          = ring_pos(r_head, CAP_M1);
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = n_head;
                                o_mem_req.wdata = i_in_item.value;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        FN_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_POP_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        FN_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ST_POP_EMPTY;
                            end else begin
                                n_head  = ring_pos(r_head, ADDR_W'(1));
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_ENDS: begin
                // store write has landed, so both ends read fresh data
                o_mem_req.raddr_a = r_head;
                o_mem_req.raddr_b = ring_pos(r_head, ADDR_W'(r_count - 1'b1));
                n_state           = S_RD_INDEX;
            end
            S_RD_INDEX: begin
                o_mem_req.raddr_a = ring_pos(r_head, ADDR_W'(r_index));
                n_state           = S_DONE;
            end
            S_DONE: begin
                // keep the indexed address so the read data holds while the result waits
                o_mem_req.raddr_a = ring_pos(r_head, ADDR_W'(r_index));
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/double_ended_queue_top.sv =====
// Double-ended queue of 256 signed 32-bit words held in a ring store with a
// head pointer and a count. Each request pushes or pops at either end, or does
// nothing, and returns one result with status, count, both end words and the
// word at the requested index. A new request is taken only in the idle state,
// once the previous one has left the sequencer: the store write happens at
// acceptance, then one state reads both ends on the two read ports and one
// more reads the indexed word, as the single memory gives two reads per
// cycle with registered read data. A finished result waits in the output
// register while the next request is taken; a further result waits in the
// sequencer and holds off new requests while that register is unread. Store
// entries need no reset; only words from written positions reach a result.
// depends on dq_pkg, dq_ctrl, dq_ram
module double_ended_queue_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dq_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dq_pkg::t_out_item o_out_item
);
    import dq_pkg::*;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_mem_req   (mem_req),
        .i_mem_rsp   (mem_rsp)
    );

    dq_ram u_ram (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.count <= 9'(DQ_CAPACITY)))
        else $error("result count beyond capacity");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.count == '0) |->
            (o_out_item.front_value == '0 && o_out_item.back_value == '0
             && o_out_item.indexed_value == '0))
        else $error("empty queue reports nonzero words");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.count == '0) |-> (o_out_item.status != ST_OK))
        else $error("empty queue reports ok status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one in flight");

endmodule

// ===== tb/sv/dq_checker.sv =====
`timescale 1ns / 1ps
// checker for the double-ended queue: watches both channels, predicts each result
// from accepted requests and compares field by field; depends on dq_pkg
module dq_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  dq_pkg::t_in_item  i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  dq_pkg::t_out_item i_out_item,
    output int                o_fail_count,
    output int                o_pending
);
    import dq_pkg::*;

    logic signed [WORD_W-1:0] ring_words [DQ_CAPACITY];
    int                       head_slot;
    int                       held_words;
    t_out_item                expected_results [$];
    int                       result_number;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        head_slot     = 0;
        held_words    = 0;
        result_number = 0;
    end

    function automatic int ring_slot(input int offset);
        return (head_slot + offset) % DQ_CAPACITY;
    endfunction

    // applies one request to the shadow queue and returns the result it should give
    function automatic t_out_item predict_result(input t_in_item req);
        t_out_item res;
        t_status   st;
        res = '0;
        st  = ST_OK;
        case (req.func)
            FN_PUSH_BACK: begin
                if (held_words >= DQ_CAPACITY) begin
                    st = ST_PUSH_FULL;
                end else begin
                    ring_words[ring_slot(held_words)] = req.value;
                    held_words++;
                end
            end
            FN_PUSH_FRONT: begin
                if (held_words >= DQ_CAPACITY) begin
                    st = ST_PUSH_FULL;
                end else begin
                    head_slot = ring_slot(DQ_CAPACITY - 1);
                    ring_words[head_slot] = req.value;
                    held_words++;
                end
            end
            FN_POP_BACK: begin
                if (held_words == 0) begin
                    st = ST_POP_EMPTY;
                end else begin
                    held_words--;
                end
            end
            FN_POP_FRONT: begin
                if (held_words == 0) begin
                    st = ST_POP_EMPTY;
                end else begin
                    head_slot = ring_slot(1);
                    held_words--;
                end
            end
            default: begin
            end
        endcase
        if (held_words != 0) begin
            res.front_value = ring_words[ring_slot(0)];
            res.back_value  = ring_words[ring_slot(held_words - 1)];
        end
        // a failed push or pop keeps its own code over a bad index
        if (int'(req.index) < held_words) begin
            res.indexed_value = ring_words[ring_slot(int'(req.index))];
        end else if (st == ST_OK) begin
            st = ST_BAD_INDEX;
        end
        res.status = st;
        res.count  = 9'(held_words);
        return res;
    endfunction

    task report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("result %0d: %s expected %h got %h", result_number, what, want, got);
        o_fail_count++;
    endtask

    task check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            report_mismatch(what, want, got);
        end
    endtask

    // sampled mid-cycle, so values match those seen by the following rising edge
    always @(negedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            head_slot  = 0;
            held_words = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending", '0, 32'(i_out_item.count));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("status", 32'(want.status), 32'(i_out_item.status));
                    check_field("count", 32'(want.count), 32'(i_out_item.count));
                    check_field("front_value", want.front_value, i_out_item.front_value);
                    check_field("back_value", want.back_value, i_out_item.back_value);
                    check_field("indexed_value", want.indexed_value, i_out_item.indexed_value);
                end
                result_number++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.insert(expected_results.size(), predict_result(i_in_item));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// testbench top for double_ended_queue_top: clock, reset, request and result
// handshakes with random idling, and the verdict; depends on dq_pkg and dq_checker
module tb_double_ended_queue_top;
    import dq_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int FILL_ITEMS   = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [2:0] FN_SPARE_A = 3'd5;
    localparam logic [2:0] FN_SPARE_B = 3'd6;
    localparam logic [2:0] FN_SPARE_C = 3'd7;

    localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_ONES = 32'hffff_ffff;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_traffic_mode;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int fail_count;
    int pending;
    int tx_idle_pct = 36;
    int rx_idle_pct = 64;
    int queue_depth = 0;
    int cycle_count = 0;

    double_ended_queue_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    dq_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_double_ended_queue_top failed");
            $finish;
        end
    end

    // issues one request and returns at the edge that accepts it
    task automatic send_request(input logic [2:0] func, input logic [31:0] value,
                                input logic [7:0] index);
        t_in_item req;
        logic     taken;
        req.func  = func;
        req.value = value;
        req.index = index;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = in_ready;
            @(posedge i_clk);
        end
        // rough depth, only used to steer the index toward held words
        if ((func == FN_PUSH_BACK || func == FN_PUSH_FRONT) && queue_depth < DQ_CAPACITY) begin
            queue_depth++;
        end else if ((func == FN_POP_BACK || func == FN_POP_FRONT) && queue_depth > 0) begin
            queue_depth--;
        end
    endtask

    function automatic logic [2:0] pick_func(input t_traffic_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 92) return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
                if (r < 96) return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            end
            MODE_DRAIN: begin
                if (r < 92) return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
                if (r < 96) return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            end
            default: begin
                if (r < 35) return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
                if (r < 70) return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            end
        endcase
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_index();
        if (queue_depth > 0 && $urandom_range(0, 99) < 75) begin
            return 8'($urandom_range(0, queue_depth - 1));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        t_traffic_mode mode;
        int            chunk_left;
        mode       = MODE_FILL;
        chunk_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: bad index, pops on empty, spare codes
        send_request(FN_NONE, pick_word(), 8'd0);
        send_request(FN_POP_BACK, pick_word(), 8'd255);
        send_request(FN_POP_FRONT, pick_word(), 8'd0);
        send_request(FN_SPARE_A, WORD_ONES, 8'd0);
        send_request(FN_SPARE_B, WORD_MAX, 8'd128);
        send_request(FN_SPARE_C, WORD_MIN, 8'd255);
        // pushes at both ends with extreme words
        send_request(FN_PUSH_BACK, WORD_MAX, 8'd0);
        send_request(FN_PUSH_FRONT, WORD_MIN, 8'd1);
        send_request(FN_PUSH_BACK, '0, 8'd2);
        send_request(FN_PUSH_FRONT, WORD_ONES, 8'd4);
        send_request(FN_PUSH_BACK, 32'h5555_5555, 8'd255);
        send_request(FN_PUSH_FRONT, 32'haaaa_aaaa, 8'd3);
        send_request(FN_NONE, pick_word(), 8'd5);
        send_request(FN_NONE, pick_word(), 8'd6);
        send_request(FN_SPARE_A, pick_word(), 8'd1);
        // pops at both ends, then empty again with a bad index
        send_request(FN_POP_BACK, pick_word(), 8'd0);
        send_request(FN_POP_FRONT, pick_word(), 8'd3);
        send_request(FN_POP_BACK, pick_word(), 8'd4);
        send_request(FN_POP_FRONT, pick_word(), 8'd1);
        send_request(FN_POP_FRONT, pick_word(), 8'd0);
        send_request(FN_POP_BACK, pick_word(), 8'd0);
        send_request(FN_POP_BACK, pick_word(), 8'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 64;
                rx_idle_pct = 36;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // fill to full, drain to empty, then random bursts
            if (n == 0) begin
                mode       = MODE_FILL;
                chunk_left = FILL_ITEMS;
            end else if (n == FILL_ITEMS) begin
                mode       = MODE_DRAIN;
                chunk_left = FILL_ITEMS;
            end else if (chunk_left == 0) begin
                mode       = t_traffic_mode'($urandom_range(0, 2));
                chunk_left = $urandom_range(20, 150);
            end
            chunk_left--;
            send_request(pick_func(mode), pick_word(), pick_index());
        end
        in_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_double_ended_queue_top passed");
        end else begin
            $display("tb_double_ended_queue_top failed");
        end
        $finish;
    end

endmodule
